// ===== rtl/framed_command_spi_slave_assert.svh =====
// Assertion macros for the framed command SPI slave.
// Depends on nothing; included by the modules that carry concurrent checks.
`ifndef FRAMED_COMMAND_SPI_SLAVE_ASSERT_SVH
`define FRAMED_COMMAND_SPI_SLAVE_ASSERT_SVH

`ifndef ASSERT_OFF

// A property that must hold at every clock edge outside reset.
`define FCS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("framed command SPI slave: check failed");

// A condition in one cycle that implies another condition in the next cycle.
`define FCS_ASSERT_NEXT(lbl, clk, rst_n, cond, next) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (next)) \
		else $error("framed command SPI slave: check failed in following cycle");

`else

`define FCS_ASSERT(lbl, clk, rst_n, prop)
`define FCS_ASSERT_NEXT(lbl, clk, rst_n, cond, next)

`endif

`endif

// ===== rtl/fcs_pkg.sv =====
// Shared types and protocol constants of the framed command SPI slave.
// Used by fcs_frame, fcs_button and framed_command_spi_slave; depends on nothing.
`default_nettype none

package fcs_pkg;

	// One input word: a SPI byte exchange or a button poll.
	typedef struct packed {
		logic       op;
		logic [7:0] mosi_byte;
		logic       button_level;
	} item_t;

	// One result word.
	typedef struct packed {
		logic [7:0] miso_byte;
		logic [1:0] button_event;
	} result_t;

	// Item kinds.
	localparam logic OP_EXCHANGE = 1'b0;
	localparam logic OP_POLL     = 1'b1;

	// Protocol bytes.
	localparam logic [7:0] BYTE_IDLE = 8'h00;
	localparam logic [7:0] BYTE_DC1  = 8'h11;
	localparam logic [7:0] BYTE_DC2  = 8'h12;
	localparam logic [7:0] BYTE_ESC  = 8'h1B;
	localparam logic [7:0] BYTE_ACK  = 8'h06;
	localparam logic [7:0] BYTE_NAK  = 8'h15;

	// Status request and the fixed part of its reply.
	localparam logic [7:0] REQ_STATUS       = 8'h53;
	localparam logic [7:0] STAT_LENGTH      = 8'h04;
	localparam logic [7:0] STAT_TAG         = 8'h41;
	localparam logic [7:0] STAT_COUNT       = 8'h01;
	localparam logic [7:0] STAT_REPLY_BYTES = 8'd7;
	localparam logic [7:0] STAT_SUM_BASE    =
		8'(BYTE_DC1 + STAT_LENGTH + BYTE_ESC + STAT_TAG + STAT_COUNT);

	// Touch states and button events.
	localparam logic [1:0] EVENT_NONE = 2'd0;
	localparam logic [1:0] TOUCH_DOWN = 2'd1;
	localparam logic [1:0] TOUCH_UP   = 2'd2;
	localparam logic [1:0] TOUCH_SUM  = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/fcs_frame.sv =====
// Frame engine: the DC1/DC2 frame state machine, sum check and reply sequencing.
// Depends on fcs_pkg.
`default_nettype none

module fcs_frame (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step_en,
	input  wire logic [7:0] mosi_byte,
	input  wire logic [1:0] touch_state,
	output logic      [7:0] reply
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_CMD  = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;
	localparam logic [1:0] PH_RESP = 2'd3;

	logic [1:0] phase_q, phase_d;
	logic [7:0] reply_q, reply_d;
	logic       dc2_q, dc2_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] len_q, len_d;
	logic [7:0] pos_q, pos_d;
	logic [7:0] first_q, first_d;
	logic [1:0] latch_q, latch_d;
	logic [7:0] status_byte;
	logic       frame_ok;
	logic [7:0] reply_len;

	// Byte of the status reply at the current position.
	always_comb begin
		case (pos_q)
			8'd0:    status_byte = fcs_pkg::BYTE_DC1;
			8'd1:    status_byte = fcs_pkg::STAT_LENGTH;
			8'd2:    status_byte = fcs_pkg::BYTE_ESC;
			8'd3:    status_byte = fcs_pkg::STAT_TAG;
			8'd4:    status_byte = fcs_pkg::STAT_COUNT;
			8'd5:    status_byte = {6'd0, latch_q};
			default: status_byte = 8'(fcs_pkg::STAT_SUM_BASE + {6'd0, latch_q});
		endcase
	end

	// Frame acceptance at the check byte: DC1 always, DC2 only for a status request.
	always_comb begin
		if (!dc2_q) begin
			frame_ok  = 1'b1;
			reply_len = 8'd0;
		end else if (pos_q == 8'd1 && first_q == fcs_pkg::REQ_STATUS) begin
			frame_ok  = 1'b1;
			reply_len = fcs_pkg::STAT_REPLY_BYTES;
		end else begin
			frame_ok  = 1'b0;
			reply_len = 8'd0;
		end
	end

	// Next-state logic for one exchanged byte.
	always_comb begin
		phase_d = phase_q;
		reply_d = reply_q;
		dc2_d   = dc2_q;
		sum_d   = sum_q;
		len_d   = len_q;
		pos_d   = pos_q;
		first_d = first_q;
		latch_d = latch_q;
		if (step_en) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (mosi_byte == fcs_pkg::BYTE_DC1 || mosi_byte == fcs_pkg::BYTE_DC2) begin
						dc2_d   = (mosi_byte == fcs_pkg::BYTE_DC2);
						sum_d   = mosi_byte;
						reply_d = fcs_pkg::BYTE_IDLE;
						phase_d = PH_CMD;
					end else if (mosi_byte == fcs_pkg::BYTE_IDLE) begin
						reply_d = fcs_pkg::BYTE_IDLE;
					end else begin
						reply_d = fcs_pkg::BYTE_NAK;
					end
				end
				PH_CMD: begin
					sum_d   = 8'(sum_q + mosi_byte);
					len_d   = mosi_byte;
					pos_d   = 8'd0;
					reply_d = fcs_pkg::BYTE_IDLE;
					phase_d = PH_DATA;
				end
				PH_DATA: begin
					if (len_q > pos_q) begin
						sum_d = 8'(sum_q + mosi_byte);
						if (pos_q == 8'd0) begin
							first_d = mosi_byte;
						end
						pos_d   = 8'(pos_q + 8'd1);
						reply_d = fcs_pkg::BYTE_IDLE;
					end else if (sum_q == mosi_byte && frame_ok) begin
						if (dc2_q) begin
							latch_d = touch_state;
						end
						pos_d   = 8'd0;
						len_d   = reply_len;
						reply_d = fcs_pkg::BYTE_ACK;
						phase_d = PH_RESP;
					end else begin
						reply_d = fcs_pkg::BYTE_NAK;
						phase_d = PH_IDLE;
					end
				end
				PH_RESP: begin
					if (mosi_byte == fcs_pkg::BYTE_IDLE && len_q > pos_q) begin
						reply_d = status_byte;
						pos_d   = 8'(pos_q + 8'd1);
					end else if (mosi_byte == fcs_pkg::BYTE_IDLE) begin
						reply_d = fcs_pkg::BYTE_IDLE;
						phase_d = PH_IDLE;
					end else begin
						reply_d = fcs_pkg::BYTE_NAK;
						phase_d = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// Control and frame state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			reply_q <= 8'd0;
			dc2_q   <= 1'b0;
			sum_q   <= 8'd0;
			len_q   <= 8'd0;
			pos_q   <= 8'd0;
			latch_q <= 2'd0;
		end else begin
			phase_q <= phase_d;
			reply_q <= reply_d;
			dc2_q   <= dc2_d;
			sum_q   <= sum_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
			latch_q <= latch_d;
		end
	end

	// The first data byte is always written before it is read.
	always_ff @(posedge clk) begin
		first_q <= first_d;
	end

	assign reply = reply_q;

endmodule

`default_nettype wire

// ===== rtl/fcs_button.sv =====
// Button edge detector and simulated touch state.
// Depends on fcs_pkg.
`default_nettype none

module fcs_button (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       poll_en,
	input  wire logic       button_level,
	output logic      [1:0] touch_state,
	output logic      [1:0] button_event
);

	logic       prev_q;
	logic [1:0] touch_q;
	logic       press;
	logic       release_seen;
	logic [1:0] touch_toggled;

	// A press is a rising level between two polls; each press toggles the touch.
	assign press         = poll_en && !prev_q && button_level;
	assign release_seen  = poll_en && prev_q && !button_level;
	assign touch_toggled = 2'(fcs_pkg::TOUCH_SUM - touch_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 1'b0;
			touch_q <= fcs_pkg::TOUCH_UP;
		end else if (press) begin
			prev_q  <= 1'b1;
			touch_q <= touch_toggled;
		end else if (release_seen) begin
			prev_q  <= 1'b0;
		end
	end

	assign touch_state  = touch_q;
	assign button_event = press ? touch_toggled : fcs_pkg::EVENT_NONE;

endmodule

`default_nettype wire

// ===== rtl/framed_command_spi_slave.sv =====
// Framed command SPI slave: input register, frame engine, button logic, result register.
// Depends on fcs_pkg, fcs_frame, fcs_button and framed_command_spi_slave_assert.svh.
`default_nettype none

`include "framed_command_spi_slave_assert.svh"

// Display-side slave for the DC1/DC2 framed command protocol. Each word is either
// a SPI byte exchange, which returns the reply byte armed by the previous exchange,
// or a button poll, which reports touch down or touch up on each button press.
// The block takes one word every clock cycle while the result side does not stall:
// a word is held in an input register, handled by the frame engine or the button
// logic, and its result is loaded into a result register, which holds it until it
// is taken. The input register keeps accepting while the result register is free
// or being emptied; the state of both engines is updated once per word.
module framed_command_spi_slave (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_stall,
	input  wire fcs_pkg::item_t  item,
	output logic                 result_valid,
	input  wire logic            result_stall,
	output fcs_pkg::result_t     result
);

	logic              valid_s1;
	fcs_pkg::item_t    item_s1;
	logic              out_free;
	logic              fire_s1;
	logic              frame_en;
	logic              poll_en;
	logic [7:0]        reply;
	logic [1:0]        touch_state;
	logic [1:0]        button_event;
	fcs_pkg::result_t  result_d;
	logic              result_valid_q;
	fcs_pkg::result_t  result_q;

	// Handshake between the input register and the result register.
	assign out_free   = !result_valid_q || !result_stall;
	assign fire_s1    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign frame_en   = fire_s1 && (item_s1.op == fcs_pkg::OP_EXCHANGE);
	assign poll_en    = fire_s1 && (item_s1.op == fcs_pkg::OP_POLL);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall) begin
			item_s1 <= item;
		end
	end

	fcs_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (frame_en),
		.mosi_byte   (item_s1.mosi_byte),
		.touch_state (touch_state),
		.reply       (reply)
	);

	fcs_button u_button (
		.clk          (clk),
		.arst_n       (arst_n),
		.poll_en      (poll_en),
		.button_level (item_s1.button_level),
		.touch_state  (touch_state),
		.button_event (button_event)
	);

	// Result word: the armed reply on exchanges, the button event on polls.
	always_comb begin
		if (item_s1.op == fcs_pkg::OP_POLL) begin
			result_d.miso_byte    = fcs_pkg::BYTE_IDLE;
			result_d.button_event = button_event;
		end else begin
			result_d.miso_byte    = reply;
			result_d.button_event = fcs_pkg::EVENT_NONE;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= fire_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// The input side only stalls while a word is held.
	`FCS_ASSERT(a_stall_needs_word, clk, arst_n, !item_stall || valid_s1)
	// Every handled word produces a result in the next cycle.
	`FCS_ASSERT_NEXT(a_fire_gives_result, clk, arst_n, fire_s1, result_valid)
	// A poll never returns a SPI reply byte.
	`FCS_ASSERT_NEXT(a_poll_no_miso, clk, arst_n, poll_en, result.miso_byte == fcs_pkg::BYTE_IDLE)
	// An exchange never reports a button event.
	`FCS_ASSERT_NEXT(a_exchange_no_event, clk, arst_n, frame_en,
		result.button_event == fcs_pkg::EVENT_NONE)
	// The touch state is only ever down or up.
	`FCS_ASSERT(a_touch_valid, clk, arst_n,
		touch_state == fcs_pkg::TOUCH_DOWN || touch_state == fcs_pkg::TOUCH_UP)

endmodule

`default_nettype wire
